@@ design/pdba_pkg.sv @@
// Shared constants, item type and tables for the phase-delay beam accumulator.
// No dependencies.
package pdba_pkg;

  // Array sizes
  localparam int PIXELS   = 64;
  localparam int ANTENNAS = 16;
  localparam int CHANNELS = 256;
  localparam int CELLS    = PIXELS * CHANNELS;
  localparam int DELAYS   = PIXELS * ANTENNAS;
  localparam int CELL_W   = $clog2(CELLS);
  localparam int DLY_W    = $clog2(DELAYS);

  // Datapath widths
  localparam int ACC_W    = 48;
  localparam int XW       = 36;   // CORDIC x/y, scaled by 2^16
  localparam int ZW       = 33;   // CORDIC residual angle
  localparam int PW       = XW + 17;
  localparam int RW       = PW - 32;
  localparam int ITERS    = 16;
  localparam int IT_W     = 4;
  localparam logic [16:0] GAIN_Q16 = 17'd39797;

  // Queue between front and back
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;

  // Input command codes
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_LOAD  = 3'd1;
  localparam logic [2:0] CMD_CART  = 3'd2;
  localparam logic [2:0] CMD_POLAR = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Internal operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Classified item as queued for the back end
  typedef struct packed {
    logic [1:0]        op;
    logic              polar;
    logic              ok;
    logic [DLY_W-1:0]  dly_addr;
    logic [CELL_W-1:0] cell_addr;
    logic [15:0]       freq;
    logic [15:0]       offs;
    logic [15:0]       sa;
    logic [15:0]       sb;
    logic [31:0]       dval;
  } pdba_item_t;

  // Back end status seen by the front
  typedef struct packed {
    logic init_busy;
  } pdba_stat_t;

  // atan(2^-i) in turns times 2^32
  function automatic logic [ZW-1:0] atan_turns(input logic [IT_W-1:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      4'd0:    v = ZW'(536870912);
      4'd1:    v = ZW'(316933406);
      4'd2:    v = ZW'(167458907);
      4'd3:    v = ZW'(85004756);
      4'd4:    v = ZW'(42667331);
      4'd5:    v = ZW'(21354461);
      4'd6:    v = ZW'(10679838);
      4'd7:    v = ZW'(5340245);
      4'd8:    v = ZW'(2670163);
      4'd9:    v = ZW'(1335087);
      4'd10:   v = ZW'(667544);
      4'd11:   v = ZW'(333772);
      4'd12:   v = ZW'(166886);
      4'd13:   v = ZW'(83443);
      4'd14:   v = ZW'(41722);
      4'd15:   v = ZW'(20861);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ design/phase_delay_beam_accumulator_top.sv @@
// Top level of the phase-delay beam accumulator: front end, item queue, back end.
// Depends on pdba_pkg, pdba_front, pdba_queue, pdba_back.
//
// After reset the block sweeps the 16384-cell accumulator store to zero and
// holds in_stall high meanwhile. Items then flow through a four-entry queue
// into a back end that works on one item at a time: a delay load is written
// into the table as it is popped, a read goes through a registered store
// read, then the output register, an add through a delay read, phase multiply,
// 16 CORDIC iterations of one shared rotation stage, gain multiply and
// read-modify-write of the store, and a clear through the queue pop, then one
// cell per cycle through the store's single write port. Unused commands and
// out-of-range loads or adds are taken and dropped by the front end without
// reaching the queue.
module phase_delay_beam_accumulator_top import pdba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_pixel,
  input  logic [3:0]  in_antenna,
  input  logic [7:0]  in_channel,
  input  logic [15:0] in_freq,
  input  logic [15:0] in_offset_phase,
  input  logic signed [15:0] in_sample_a,
  input  logic signed [15:0] in_sample_b,
  input  logic signed [31:0] in_delay_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [47:0] out_beam_real,
  output logic signed [47:0] out_beam_imag
);

  pdba_stat_t stat;
  pdba_item_t push_item, head;
  logic       push, full, pop, nempty;

  pdba_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_pixel, .in_antenna,
    .in_channel, .in_freq, .in_offset_phase, .in_sample_a, .in_sample_b,
    .in_delay_value, .stat, .q_full(full), .q_push(push), .q_item(push_item)
  );

  pdba_queue u_queue (
    .clk, .rst_n, .push, .push_item, .full, .pop, .nempty, .head
  );

  pdba_back u_back (
    .clk, .rst_n, .q_nempty(nempty), .q_head(head), .q_pop(pop), .stat,
    .out_valid, .out_stall, .out_beam_real, .out_beam_imag
  );

endmodule

@@ design/pdba_front.sv @@
// Front end: accepts input items, checks ranges, forms addresses, drops no-ops.
// Depends on pdba_pkg.
module pdba_front import pdba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_pixel,
  input  logic [3:0]  in_antenna,
  input  logic [7:0]  in_channel,
  input  logic [15:0] in_freq,
  input  logic [15:0] in_offset_phase,
  input  logic signed [15:0] in_sample_a,
  input  logic signed [15:0] in_sample_b,
  input  logic signed [31:0] in_delay_value,
  input  pdba_stat_t  stat,
  input  logic        q_full,
  output logic        q_push,
  output pdba_item_t  q_item
);

  logic pix_ok, ant_ok, ch_ok, keep;
  logic seen_r;

  // Stall after reset until this register is set, before the status is trusted
  always_ff @(posedge clk) begin
    if (!rst_n) seen_r <= 1'b0;
    else        seen_r <= 1'b1;
  end

  assign pix_ok = int'(in_pixel) < PIXELS;
  assign ant_ok = int'(in_antenna) < ANTENNAS;
  assign ch_ok  = int'(in_channel) < CHANNELS;

  // Classify the command
  always_comb begin
    q_item           = '0;
    q_item.dly_addr  = DLY_W'(int'(in_pixel) * ANTENNAS + int'(in_antenna));
    q_item.cell_addr = CELL_W'(int'(in_pixel) * CHANNELS + int'(in_channel));
    q_item.freq      = in_freq;
    q_item.offs      = in_offset_phase;
    q_item.sa        = in_sample_a;
    q_item.sb        = in_sample_b;
    q_item.dval      = in_delay_value;
    keep             = 1'b0;
    unique case (in_command)
      CMD_CLEAR: begin
        q_item.op = OP_CLEAR;
        keep      = 1'b1;
      end
      CMD_LOAD: begin
        q_item.op = OP_LOAD;
        keep      = pix_ok & ant_ok;
      end
      CMD_CART, CMD_POLAR: begin
        q_item.op    = OP_ADD;
        q_item.polar = (in_command == CMD_POLAR);
        keep         = pix_ok & ant_ok & ch_ok;
      end
      CMD_READ: begin
        q_item.op = OP_READ;
        q_item.ok = pix_ok & ch_ok;
        keep      = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = q_full | stat.init_busy | ~seen_r;
  assign q_push   = in_valid & ~in_stall & keep;

endmodule

@@ design/pdba_queue.sv @@
// Short item queue between front and back end.
// Depends on pdba_pkg.
module pdba_queue import pdba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pdba_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       nempty,
  output pdba_item_t head
);

  pdba_item_t        ent_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign full   = (int'(cnt_r) == QDEPTH);
  assign nempty = (cnt_r != '0);
  assign head   = ent_r[rp_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ design/pdba_back.sv @@
// Back end: delay table, phase multiply, iterative CORDIC, saturating
// accumulator store with clearing sweep, and the output register. Uses pdba_pkg.
module pdba_back import pdba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nempty,
  input  pdba_item_t  q_head,
  output logic        q_pop,
  output pdba_stat_t  stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [ACC_W-1:0] out_beam_real,
  output logic signed [ACC_W-1:0] out_beam_imag
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_DLY   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_PH    = 4'd4;
  localparam logic [3:0] S_ROT   = 4'd5;
  localparam logic [3:0] S_GAIN  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_RDS   = 4'd8;
  localparam logic [3:0] S_RDO   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  pdba_item_t        cur_r;
  logic              init_r;
  logic [CELL_W-1:0] sweep_r;
  logic [IT_W-1:0]   it_r;
  logic [31:0]       prod_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [PW-1:0] px_r, py_r;

  // Memories
  logic [31:0]      dly_mem [DELAYS];
  logic [31:0]      dly_q;
  logic [ACC_W-1:0] re_mem [CELLS];
  logic [ACC_W-1:0] im_mem [CELLS];
  logic [ACC_W-1:0] re_q, im_q;
  logic             st_we;
  logic [CELL_W-1:0] st_waddr;
  logic [ACC_W-1:0] st_wre, st_wim;

  logic out_valid_r;
  logic [ACC_W-1:0] out_re_r, out_im_r;
  logic out_load;

  assign stat.init_busy = init_r;
  assign q_pop = (state_r == S_IDLE) & q_nempty;

  // Delay table: written on a load pop, read at the current item
  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == OP_LOAD) dly_mem[q_head.dly_addr] <= q_head.dval;
    dly_q <= dly_mem[cur_r.dly_addr];
  end

  // Accumulator store
  always_ff @(posedge clk) begin
    if (st_we) begin
      re_mem[st_waddr] <= st_wre;
      im_mem[st_waddr] <= st_wim;
    end
    re_q <= re_mem[cur_r.cell_addr];
    im_q <= im_mem[cur_r.cell_addr];
  end

  // Phase and starting vector
  logic [31:0] phase;
  logic signed [XW-1:0] xa, xb;
  always_comb begin
    phase = prod_r + {cur_r.offs, 16'b0} + (cur_r.polar ? {cur_r.sb, 16'b0} : 32'd0);
    xa    = {{(XW-32){cur_r.sa[15]}}, cur_r.sa, 16'b0};
    xb    = cur_r.polar ? '0 : {{(XW-32){cur_r.sb[15]}}, cur_r.sb, 16'b0};
  end

  // One CORDIC step
  logic signed [XW-1:0] dx, dy, x_step, y_step;
  logic signed [ZW-1:0] at, z_step;
  always_comb begin
    dx = y_r >>> it_r;
    dy = x_r >>> it_r;
    at = $signed(atan_turns(it_r));
    if (!z_r[ZW-1]) begin
      x_step = x_r - dx;
      y_step = y_r + dy;
      z_step = z_r - at;
    end else begin
      x_step = x_r + dx;
      y_step = y_r - dy;
      z_step = z_r + at;
    end
  end

  // Gain rounding and saturating accumulate
  logic signed [PW-1:0]      rx, ry;
  logic signed [ACC_W:0]     sr, si;
  logic [ACC_W-1:0]          ar, ai;
  always_comb begin
    rx = px_r + PW'(64'sd2147483648);
    ry = py_r + PW'(64'sd2147483648);
    sr = {re_q[ACC_W-1], re_q} + {{(ACC_W+1-RW){rx[PW-1]}}, rx[PW-1:32]};
    si = {im_q[ACC_W-1], im_q} + {{(ACC_W+1-RW){ry[PW-1]}}, ry[PW-1:32]};
    if (sr[ACC_W] != sr[ACC_W-1]) ar = {sr[ACC_W], {(ACC_W-1){~sr[ACC_W]}}};
    else                          ar = sr[ACC_W-1:0];
    if (si[ACC_W] != si[ACC_W-1]) ai = {si[ACC_W], {(ACC_W-1){~si[ACC_W]}}};
    else                          ai = si[ACC_W-1:0];
  end

  // Store write port: sweep or accumulate
  always_comb begin
    st_we    = (state_r == S_SWEEP) | (state_r == S_ACC);
    st_waddr = (state_r == S_SWEEP) ? sweep_r : cur_r.cell_addr;
    st_wre   = (state_r == S_SWEEP) ? '0 : ar;
    st_wim   = (state_r == S_SWEEP) ? '0 : ai;
  end

  assign out_load = (state_r == S_RDO) & (~out_valid_r | ~out_stall);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_nempty) begin
          unique case (q_head.op)
            OP_CLEAR: state_nxt = S_SWEEP;
            OP_LOAD:  state_nxt = S_IDLE;
            OP_ADD:   state_nxt = S_DLY;
            OP_READ:  state_nxt = S_RDS;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_SWEEP: if (sweep_r == CELL_W'(CELLS - 1)) state_nxt = S_IDLE;
      S_DLY:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_PH;
      S_PH:    state_nxt = S_ROT;
      S_ROT:   if (it_r == IT_W'(ITERS - 1)) state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_ACC;
      S_ACC:   state_nxt = S_IDLE;
      S_RDS:   state_nxt = S_RDO;
      S_RDO:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      init_r      <= 1'b1;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SWEEP) begin
        sweep_r <= sweep_r + 1'b1;
        if (sweep_r == CELL_W'(CELLS - 1)) begin
          sweep_r <= '0;
          init_r  <= 1'b0;
        end
      end
      if (out_load)            out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (state_r == S_MUL) prod_r <= 32'(dly_q * {16'b0, cur_r.freq});
    if (state_r == S_PH) begin
      it_r <= '0;
      z_r  <= {{(ZW-30){1'b0}}, phase[29:0]};
      unique case (phase[31:30])
        2'd0: begin x_r <= xa;  y_r <= xb;  end
        2'd1: begin x_r <= -xb; y_r <= xa;  end
        2'd2: begin x_r <= -xa; y_r <= -xb; end
        2'd3: begin x_r <= xb;  y_r <= -xa; end
        default: begin x_r <= xa; y_r <= xb; end
      endcase
    end
    if (state_r == S_ROT) begin
      x_r  <= x_step;
      y_r  <= y_step;
      z_r  <= z_step;
      it_r <= it_r + 1'b1;
    end
    if (state_r == S_GAIN) begin
      px_r <= x_r * $signed(GAIN_Q16);
      py_r <= y_r * $signed(GAIN_Q16);
    end
    if (out_load) begin
      out_re_r <= cur_r.ok ? re_q : '0;
      out_im_r <= cur_r.ok ? im_q : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_beam_real = out_re_r;
  assign out_beam_imag = out_im_r;

endmodule
